// ===== rtl/core/rsbp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the record priority sorter: transaction payload types,
// sort method codes and the divide-by-ten helpers used by the radix passes.
// No dependencies.
package rsbp_pkg;

  localparam int RADIX   = 10;
  localparam int DIGIT_W = 4;

  localparam logic [1:0] SM_EXCHANGE = 2'd0;
  localparam logic [1:0] SM_RADIX    = 2'd1;
  // Both remaining codes emit the list in arrival order.
  localparam logic [1:0] SM_KEEP0    = 2'd2;
  localparam logic [1:0] SM_KEEP1    = 2'd3;

  typedef struct packed {
    logic signed [31:0] item_data;
    logic [15:0]        item_priority;
    logic               item_last;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_data;
    logic [15:0]        out_priority;
    logic               out_last;
    logic               overflow;
  } result_t;

  // Exact quotient by ten for any 16-bit value: multiply by reciprocal, shift.
  function automatic logic [15:0] div10(input logic [15:0] v);
    logic [32:0] prod;
    prod = 33'(v) * 33'd52429;
    return 16'(prod[32:19]);
  endfunction

  // Remainder by ten, taken from the quotient.
  function automatic logic [DIGIT_W-1:0] mod10(input logic [15:0] v);
    logic [15:0] q;
    logic [19:0] back;
    q    = div10(v);
    back = 20'(q) * 20'(RADIX);
    return DIGIT_W'(20'(v) - back);
  endfunction

endpackage

// ===== rtl/core/record_sort_by_priority_core.sv =====
`timescale 1ns / 1ps
// Record priority sorter: collects a list of records in on-chip memory,
// sorts it by priority (exchange sort or decimal LSD radix sort) and emits it.
// Depends on rsbp_pkg.
//
//  channel | signals                          | direction | transaction
//  --------+----------------------------------+-----------+----------------------------
//  item    | item_valid, item_ready, item     | in        | one record, last marks end
//  result  | result_valid, result_ready,      | out       | one sorted record
//          | result                           |           |
//  cfg     | cfg_valid, cfg_ready, cfg_data   | in        | write of sort_method
//
// Records load at one per cycle while item_ready is high. After the last
// record the block sorts: exchange sort makes one memory read per compare;
// radix sort makes a counting pass, a prefix sum and a scatter pass per
// decimal digit of the largest key. Each sorted record waits on the result
// channel until taken. Reset is synchronous and clears control state only;
// the record memories hold garbage until written. item_ready is low from the
// last record until the final result transaction completes.
module record_sort_by_priority_core #(
  parameter int MAX_RECORDS = 64,
  parameter int KEY_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rsbp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output rsbp_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);

  // Key width as stored: the priority field is 16 bits, so cap there.
  localparam int KW = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  // Memory entry: payload, key, and the key's running quotient for radix.
  localparam int EW = 32 + 2 * KW;

  typedef enum logic [3:0] {
    S_LOAD, S_EX_I, S_EX_IW, S_EX_J, S_EX_W,
    S_RX_INIT, S_RX_CNT, S_RX_PFX, S_RX_SCT,
    S_OUT_RD, S_OUT_WAIT, S_OUT_HOLD
  } state_t;

  state_t state;

  logic [1:0]          sort_method;
  logic [CW-1:0]       count;
  logic                dropped;
  logic                sel;       // bank that holds the current list
  logic [KW-1:0]       top;       // largest key of the list
  logic [KW-1:0]       topq;      // top divided by the current digit weight
  logic [AW-1:0]       i;
  logic [CW-1:0]       ia;        // read issue counter
  logic [AW-1:0]       ra;        // address of the read in flight
  logic                rv;        // read data valid this cycle
  logic [EW-1:0]       ri;        // record held at position i
  logic [rsbp_pkg::DIGIT_W-1:0] d;
  logic [CW-1:0]       cnt [rsbp_pkg::RADIX];

  // Two banks: loading and exchange sort use the current one, radix passes
  // read the current and scatter into the other, then swap.
  logic [EW-1:0] mem0 [MAX_RECORDS];
  logic [EW-1:0] mem1 [MAX_RECORDS];
  logic [EW-1:0] rd0, rd1, rdata;
  logic [AW-1:0] rd_addr;

  logic          we_s, we_d;
  logic [AW-1:0] wa_s, wa_d;
  logic [EW-1:0] wd_s, wd_d;
  logic          we0, we1;
  logic [AW-1:0] wa0, wa1;
  logic [EW-1:0] wd0, wd1;

  logic [31:0]   rd_data;
  logic [KW-1:0] rd_key, rd_q, rd_q_div;
  logic [rsbp_pkg::DIGIT_W-1:0] dig;
  logic [KW-1:0] key_in, topq_div;
  logic          full, ex_swap;
  logic [CW-1:0] n_after;
  logic [CW-1:0] slot;

  assign rdata    = sel ? rd1 : rd0;
  assign rd_data  = rdata[EW-1 -: 32];
  assign rd_key   = rdata[2*KW-1 -: KW];
  assign rd_q     = rdata[KW-1:0];
  assign rd_q_div = KW'(rsbp_pkg::div10(16'(rd_q)));
  assign dig      = rsbp_pkg::mod10(16'(rd_q));
  assign topq_div = KW'(rsbp_pkg::div10(16'(topq)));
  assign key_in   = item.item_priority[KW-1:0];
  assign full     = (count == CW'(MAX_RECORDS));
  assign n_after  = full ? count : count + CW'(1);
  assign ex_swap  = rv && (ri[2*KW-1 -: KW] > rd_key);
  assign slot     = cnt[dig] - CW'(1);

  assign item_ready = (state == S_LOAD);
  assign cfg_ready  = 1'b1;

  // Memory access selection
  always_comb begin
    we_s = 1'b0;
    wa_s = count[AW-1:0];
    wd_s = {item.item_data, key_in, key_in};
    we_d = 1'b0;
    wa_d = slot[AW-1:0];
    wd_d = {rd_data, rd_key, rd_q_div};
    rd_addr = '0;
    case (state)
      S_LOAD: begin
        we_s = item_valid && !full;
      end
      S_EX_I: begin
        rd_addr = i;
      end
      S_EX_IW, S_RX_CNT, S_OUT_RD: begin
        rd_addr = ia[AW-1:0];
      end
      S_EX_J: begin
        rd_addr = ia[AW-1:0];
        we_s    = ex_swap;
        wa_s    = ra;
        wd_s    = ri;
      end
      S_EX_W: begin
        we_s = 1'b1;
        wa_s = i;
        wd_s = ri;
      end
      S_RX_SCT: begin
        rd_addr = AW'(ia - CW'(1));
        we_d    = rv;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
    we0 = sel ? we_d : we_s;
    wa0 = sel ? wa_d : wa_s;
    wd0 = sel ? wd_d : wd_s;
    we1 = sel ? we_s : we_d;
    wa1 = sel ? wa_s : wa_d;
    wd1 = sel ? wd_s : wd_d;
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa0] <= wd0;
    end
    rd0 <= mem0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wa1] <= wd1;
    end
    rd1 <= mem1[rd_addr];
  end

  // Sequencer: load, sort, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      sort_method  <= rsbp_pkg::SM_EXCHANGE;
      count        <= '0;
      dropped      <= 1'b0;
      sel          <= 1'b0;
      top          <= '0;
      rv           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        sort_method <= cfg_data;
      end
      case (state)
        S_LOAD: begin
          if (item_valid) begin
            // Store while there is room, else drop and flag.
            if (!full) begin
              count <= count + CW'(1);
              if (key_in > top) begin
                top <= key_in;
              end
            end else begin
              dropped <= 1'b1;
            end
            if (item.item_last) begin
              i  <= '0;
              ia <= '0;
              rv <= 1'b0;
              case (sort_method)
                rsbp_pkg::SM_EXCHANGE: begin
                  state <= (n_after >= CW'(2)) ? S_EX_I : S_OUT_RD;
                end
                rsbp_pkg::SM_RADIX: begin
                  state <= S_RX_INIT;
                end
                default: begin
                  state <= S_OUT_RD;
                end
              endcase
            end
          end
        end
        S_EX_I: begin
          ia    <= CW'(i) + CW'(1);
          state <= S_EX_IW;
        end
        S_EX_IW: begin
          ri    <= rdata;
          ra    <= ia[AW-1:0];
          ia    <= ia + CW'(1);
          rv    <= 1'b1;
          state <= S_EX_J;
        end
        S_EX_J: begin
          // Hold the smaller key in ri; the larger one goes back at ra.
          if (ex_swap) begin
            ri <= rdata;
          end
          if (ia < count) begin
            ra <= ia[AW-1:0];
            ia <= ia + CW'(1);
            rv <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (ia == count && !rv) begin
            state <= S_EX_W;
          end
        end
        S_EX_W: begin
          i <= i + AW'(1);
          if ((CW + 1)'(i) + (CW + 1)'(2) < (CW + 1)'(count)) begin
            state <= S_EX_I;
          end else begin
            ia    <= '0;
            state <= S_OUT_RD;
          end
        end
        S_RX_INIT: begin
          topq <= top;
          ia   <= '0;
          rv   <= 1'b0;
          for (int k = 0; k < rsbp_pkg::RADIX; k++) begin
            cnt[k] <= '0;
          end
          state <= (top == '0) ? S_OUT_RD : S_RX_CNT;
        end
        S_RX_CNT: begin
          // Histogram of the current digit.
          if (ia < count) begin
            ia <= ia + CW'(1);
            rv <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (rv) begin
            cnt[dig] <= cnt[dig] + CW'(1);
          end
          if (ia == count && !rv) begin
            d     <= rsbp_pkg::DIGIT_W'(1);
            state <= S_RX_PFX;
          end
        end
        S_RX_PFX: begin
          cnt[d] <= cnt[d] + cnt[d - rsbp_pkg::DIGIT_W'(1)];
          if (d == rsbp_pkg::DIGIT_W'(rsbp_pkg::RADIX - 1)) begin
            ia    <= count;
            rv    <= 1'b0;
            state <= S_RX_SCT;
          end else begin
            d <= d + rsbp_pkg::DIGIT_W'(1);
          end
        end
        S_RX_SCT: begin
          // Scatter from the tail so equal digits keep their order.
          if (ia != '0) begin
            ia <= ia - CW'(1);
            rv <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (rv) begin
            cnt[dig] <= slot;
          end
          if (ia == '0 && !rv) begin
            sel  <= ~sel;
            topq <= topq_div;
            ia   <= '0;
            for (int k = 0; k < rsbp_pkg::RADIX; k++) begin
              cnt[k] <= '0;
            end
            state <= (topq_div == '0) ? S_OUT_RD : S_RX_CNT;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          result.out_data     <= $signed(rd_data);
          result.out_priority <= 16'(rd_key);
          result.out_last     <= (ia == count - CW'(1));
          result.overflow     <= dropped;
          result_valid        <= 1'b1;
          state               <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            if (result.out_last) begin
              count   <= '0;
              dropped <= 1'b0;
              top     <= '0;
              state   <= S_LOAD;
            end else begin
              ia    <= ia + CW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/rsbp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the record priority sorter, and the bind that
// attaches them to the top level. Depends on rsbp_pkg.
module rsbp_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input rsbp_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_ready,
  input rsbp_pkg::result_t result
);

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // No record is taken while a list is being emitted.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("input accepted during emission");

  // The final result ends emission.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result.out_last |=> !result_valid)
    else $error("result after final record");

  // A last record closes the input side.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.item_last |=> !item_ready)
    else $error("input open after last record");

  // Out of reset the block loads.
  a_reset_state: assert property (@(posedge clk)
    rst |=> item_ready && !result_valid)
    else $error("bad state after reset");

endmodule

bind record_sort_by_priority_core rsbp_checker u_rsbp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== verif/record_sort_checker.sv =====
`timescale 1ns / 1ps
// Checker for the record priority sorter: watches the item, config and result
// channels, predicts the sorted output lists and compares every result field.
// Depends on rsbp_pkg.
module record_sort_checker #(
  parameter int MAX_RECORDS = 64,
  parameter int KEY_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  rsbp_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  rsbp_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic signed [31:0] data;
    logic [15:0]        key;
  } rec_t;

  rec_t              held_list[$];
  logic              list_dropped;
  logic [1:0]        method_reg;
  rsbp_pkg::result_t expected_results[$];

  assign pending_count = expected_results.size();

  function automatic logic [15:0] digit_of(logic [15:0] k, int unsigned pos);
    return 16'((k / pos) % 10);
  endfunction

  // Sort the held list by the chosen method and queue one result per record.
  task automatic emit_sorted_list();
    rec_t              arr[$];
    rec_t              tmp;
    rec_t              bucket[$];
    rsbp_pkg::result_t r;
    logic [15:0]       top;
    int unsigned       pos;
    arr = held_list;
    if (method_reg == rsbp_pkg::SM_EXCHANGE) begin
      for (int i = 0; i < arr.size(); i++)
        for (int j = i + 1; j < arr.size(); j++)
          if (arr[i].key > arr[j].key) begin
            tmp = arr[i]; arr[i] = arr[j]; arr[j] = tmp;
          end
    end else if (method_reg == rsbp_pkg::SM_RADIX) begin
      top = 0;
      foreach (arr[i]) if (arr[i].key > top) top = arr[i].key;
      // Stable distribution pass per decimal digit.
      for (pos = 1; (top / pos) > 0; pos *= 10) begin
        bucket = {};
        for (int d = 0; d < 10; d++)
          foreach (arr[i]) if (digit_of(arr[i].key, pos) == 16'(d)) bucket.push_back(arr[i]);
        arr = bucket;
      end
    end
    foreach (arr[i]) begin
      r.out_data     = arr[i].data;
      r.out_priority = arr[i].key;
      r.out_last     = (i == arr.size() - 1);
      r.overflow     = list_dropped;
      expected_results.push_back(r);
    end
    held_list    = {};
    list_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_list    = {};
      list_dropped = 1'b0;
      method_reg   = rsbp_pkg::SM_EXCHANGE;
      fail_count   = 0;
      expected_results = {};
    end else begin
      if (cfg_valid && cfg_ready) method_reg = cfg_data;
      if (item_valid && item_ready) begin
        if (held_list.size() < MAX_RECORDS)
          held_list.push_back({item.item_data,
                               16'(item.item_priority & ((1 << KEY_BITS) - 1))});
        else
          list_dropped = 1'b1;
        if (item.item_last) emit_sorted_list();
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: data %0d", result.out_data);
          fail_count++;
        end else begin
          rsbp_pkg::result_t e;
          e = expected_results.pop_front();
          if (e.out_data !== result.out_data) begin
            $error("out_data: expected %0d, got %0d", e.out_data, result.out_data);
            fail_count++;
          end
          if (e.out_priority !== result.out_priority) begin
            $error("out_priority: expected %0d, got %0d", e.out_priority, result.out_priority);
            fail_count++;
          end
          if (e.out_last !== result.out_last) begin
            $error("out_last: expected %0b, got %0b", e.out_last, result.out_last);
            fail_count++;
          end
          if (e.overflow !== result.overflow) begin
            $error("overflow: expected %0b, got %0b", e.overflow, result.overflow);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb_record_sort_by_priority_core.sv =====
`timescale 1ns / 1ps
// Testbench top for record_sort_by_priority_core: drives record lists and method
// writes with random gaps and stalls; record_sort_checker predicts and compares.
// Depends on rsbp_pkg, record_sort_by_priority_core and record_sort_checker.
module tb_record_sort_by_priority_core;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  rsbp_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  rsbp_pkg::result_t result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_data = '0;
  int                fail_count;
  int                pending_count;
  int                records_sent;

  always #2 clk = ~clk;

  record_sort_by_priority_core dut (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .cfg_valid, .cfg_ready, .cfg_data
  );

  record_sort_checker checker_i (
    .clk, .rst, .item_valid, .item_ready, .item, .result_valid, .result_ready,
    .result, .cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending_count
  );

  // Result side: draw a random stall before each transaction, and run some
  // stretches with ready held high.
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      if ($urandom_range(3) == 0) stall = 0;
      else stall = $urandom_range(7);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Send one record: wait a random gap, hold valid until accepted.
  task automatic send_record(logic signed [31:0] d, logic [15:0] p, logic lst, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(7) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{item_data: d, item_priority: p, item_last: lst};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
    records_sent++;
  endtask

  // Drop valid, drain all expected results, let the block settle, then write
  // the method register.
  task automatic write_method(logic [1:0] m);
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send a list of n records with random content; keys drawn from a small
  // range now and then to force many ties.
  task automatic send_list(int n, bit gaps);
    logic [15:0] p;
    int          kind;
    kind = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: p = 16'($urandom_range(3));
        1: p = 16'($urandom_range(99));
        default: p = 16'($urandom);
      endcase
      send_record($urandom, p, i == n - 1, gaps);
    end
  endtask

  initial begin
    records_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset method is exchange; extremes of data and key, ties.
    send_record(32'sh7FFFFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_record(32'sh80000000, 16'h0000, 1'b0, 1'b0);
    send_record(32'sd5, 16'd7, 1'b0, 1'b0);
    send_record(-32'sd1, 16'd7, 1'b0, 1'b0);
    send_record(32'sd0, 16'd7, 1'b1, 1'b0);
    // Single-record list.
    send_record(32'sd42, 16'd3, 1'b1, 1'b0);
    write_method(rsbp_pkg::SM_RADIX);
    // All zero keys: no radix pass, order kept.
    send_record(32'sd1, 16'd0, 1'b0, 1'b0);
    send_record(32'sd2, 16'd0, 1'b0, 1'b0);
    send_record(32'sd3, 16'd0, 1'b1, 1'b0);
    send_record(32'sd9, 16'd65535, 1'b0, 1'b0);
    send_record(32'sd8, 16'd10, 1'b0, 1'b0);
    send_record(32'sd7, 16'd10, 1'b0, 1'b0);
    send_record(-32'sd6, 16'd1, 1'b1, 1'b0);
    write_method(rsbp_pkg::SM_KEEP0);
    send_record(32'sd11, 16'd9, 1'b0, 1'b0);
    send_record(32'sd12, 16'd1, 1'b1, 1'b0);
    write_method(rsbp_pkg::SM_KEEP1);
    send_record(32'sd13, 16'd9, 1'b0, 1'b0);
    send_record(32'sd14, 16'd1, 1'b1, 1'b0);

    // Store full: overflowing list with the last record dropped, for both
    // sorting methods.
    for (int m = 0; m < 2; m++) begin
      write_method(2'(m));
      send_list(66, 1'b0);
    end

    // Random lists in groups, method rewritten before each group; mostly short lists.
    while (records_sent < 260) begin
      write_method(2'($urandom_range(3)));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(15) == 0) send_list($urandom_range(60, 66), 1'b1);
        else send_list($urandom_range(1, 12), $urandom_range(3) != 0);
      end
    end

    item_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("** record_sort_by_priority_core: PASSED **");
    else $display("** record_sort_by_priority_core: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** record_sort_by_priority_core: FAILED **");
    $finish;
  end
endmodule
